>>> rtl/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg: shared types and constants of the triangle tangent unit
// Field widths, fixed-point formats and pipeline depths used by the
// normalizer and the top level.
// ----------------------------------------------------------------------------
package tcc_pkg;

  localparam int POS_WIDTH = 20;
  localparam int UV_WIDTH  = 16;
  localparam int VEC_WIDTH = 16;

  // Unit vectors are signed Q2.FRAC.
  localparam int FRAC  = VEC_WIDTH - 2;
  localparam int GUARD = 8;

  // Magnitudes are shifted below 2^MAG_BITS before squaring.
  localparam int MAG_BITS = 22;

  // Width of a normalizer input component: wide enough for every edge and
  // for the difference of two products of unit components.
  localparam int W_POS = POS_WIDTH + 1;
  localparam int W_UV  = UV_WIDTH + 1;
  localparam int W_RAW = 2 * VEC_WIDTH + 2;
  localparam int W_AB  = (W_POS > W_UV) ? W_POS : W_UV;
  localparam int W_ABR = (W_AB > W_RAW) ? W_AB : W_RAW;
  localparam int NIN_W = (W_ABR > MAG_BITS + 1) ? W_ABR : MAG_BITS + 1;
  localparam int SH_W  = $clog2(NIN_W - MAG_BITS + 1);

  // Sum of three squares, the radicand and its root.
  localparam int SQ_W   = 2 * MAG_BITS + 2;
  localparam int RAD_W  = SQ_W + 2 * GUARD;
  localparam int ROOT_W = (RAD_W + 1) / 2;
  localparam int SQX_W  = 2 * ROOT_W + 2;
  localparam int SQ_PER = 4;
  localparam int SQ_ST  = (ROOT_W + SQ_PER - 1) / SQ_PER;

  // Quotient of the component divide and its numerator.
  localparam int Q_W    = FRAC + 1;
  localparam int NUM_W  = MAG_BITS + FRAC + GUARD + 1;
  localparam int DV_PER = 4;
  localparam int DV_ST  = (Q_W + DV_PER - 1) / DV_PER;

  // Register stages from normalizer input to normalizer output.
  localparam int NRM_LAT = 4 + SQ_ST + DV_ST;

  typedef logic signed [NIN_W-1:0]       nin_t;
  typedef logic signed [VEC_WIDTH-1:0]   vec_t;
  typedef logic signed [2*VEC_WIDTH-1:0] prod_t;

  localparam vec_t VEC_ONE = {2'b01, {FRAC{1'b0}}};

endpackage

>>> rtl/tcc_norm.sv
// ----------------------------------------------------------------------------
// tcc_norm: pipelined three-component vector normalizer
// Scales the magnitudes below 2^MAG_BITS, sums the squares, takes a
// digit-by-digit square root and divides each component by the length.
// ----------------------------------------------------------------------------
module tcc_norm (
  input  logic          clk,
  input  logic          en,
  input  tcc_pkg::nin_t vec [3],
  output tcc_pkg::vec_t res [3]
);
  import tcc_pkg::*;

  // Stage 1: sign, magnitude and common right shift.
  logic [NIN_W-1:0]    mag_c [3];
  logic [NIN_W-1:0]    or_c;
  logic [SH_W-1:0]     sh_c;
  logic [MAG_BITS-1:0] m1 [3];
  logic                n1 [3];

  always_comb begin
    or_c = '0;
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = vec[i][NIN_W-1] ? NIN_W'(-vec[i]) : NIN_W'(vec[i]);
      or_c     = or_c | mag_c[i];
    end
    sh_c = '0;
    for (int b = MAG_BITS; b < NIN_W; b++) begin
      if (or_c[b]) begin
        sh_c = SH_W'(b - MAG_BITS + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m1[i] <= MAG_BITS'(mag_c[i] >> sh_c);
        n1[i] <= vec[i][NIN_W-1];
      end
    end
  end

  // Stage 2: squares.
  logic [2*MAG_BITS-1:0] sq2 [3];
  logic [MAG_BITS-1:0]   m2 [3];
  logic                  n2 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq2[i] <= m1[i] * m1[i];
        m2[i]  <= m1[i];
        n2[i]  <= n1[i];
      end
    end
  end

  // Stage 3: sum of squares, scaled into the radicand.
  logic [SQ_W-1:0]     sum_c;
  logic [SQX_W-1:0]    sx [SQ_ST+1];
  logic [SQX_W-1:0]    sr [SQ_ST+1];
  logic [MAG_BITS-1:0] sm [SQ_ST+1][3];
  logic                sn [SQ_ST+1][3];
  logic                sz [SQ_ST+1];

  assign sum_c = SQ_W'(sq2[0]) + SQ_W'(sq2[1]) + SQ_W'(sq2[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      sx[0] <= SQX_W'({sum_c, {(2*GUARD){1'b0}}});
      sr[0] <= '0;
      sz[0] <= (sum_c == '0);
      for (int i = 0; i < 3; i++) begin
        sm[0][i] <= m2[i];
        sn[0][i] <= n2[i];
      end
    end
  end

  // Square root, SQ_PER result bits per stage.
  for (genvar g = 0; g < SQ_ST; g++) begin : g_sqrt
    logic [SQX_W-1:0] x_c, r_c, t_c, bit_c;

    always_comb begin
      int k;
      x_c   = sx[g];
      r_c   = sr[g];
      t_c   = '0;
      bit_c = '0;
      for (int j = 0; j < SQ_PER; j++) begin
        k = ROOT_W - 1 - SQ_PER * g - j;
        if (k >= 0) begin
          bit_c = SQX_W'(1) << (2 * k);
          t_c   = r_c + bit_c;
          if (x_c >= t_c) begin
            x_c = x_c - t_c;
            r_c = (r_c >> 1) + bit_c;
          end else begin
            r_c = r_c >> 1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sx[g+1] <= x_c;
        sr[g+1] <= r_c;
        sz[g+1] <= sz[g];
        for (int i = 0; i < 3; i++) begin
          sm[g+1][i] <= sm[g][i];
          sn[g+1][i] <= sn[g][i];
        end
      end
    end
  end

  // Component divide by the length, DV_PER quotient bits per stage.
  logic [ROOT_W-1:0] dl [DV_ST+1];
  logic [ROOT_W:0]   dr [DV_ST+1][3];
  logic [Q_W-1:0]    dq [DV_ST+1][3];
  logic [Q_W-1:0]    dn [DV_ST+1][3];
  logic              dneg [DV_ST+1][3];
  logic              dz [DV_ST+1];
  logic [NUM_W-1:0]  num_c [3];

  always_comb begin
    dl[0] = sr[SQ_ST][ROOT_W-1:0];
    dz[0] = sz[SQ_ST];
    for (int i = 0; i < 3; i++) begin
      num_c[i]   = (NUM_W'(sm[SQ_ST][i]) << (FRAC + GUARD)) + NUM_W'(dl[0] >> 1);
      dr[0][i]   = (ROOT_W+1)'(num_c[i] >> Q_W);
      dn[0][i]   = num_c[i][Q_W-1:0];
      dq[0][i]   = '0;
      dneg[0][i] = sn[SQ_ST][i];
    end
  end

  for (genvar d = 0; d < DV_ST; d++) begin : g_div
    logic [ROOT_W:0] r_c [3];
    logic [Q_W-1:0]  q_c [3];

    always_comb begin
      int bp;
      for (int i = 0; i < 3; i++) begin
        r_c[i] = dr[d][i];
        q_c[i] = dq[d][i];
        for (int j = 0; j < DV_PER; j++) begin
          bp = Q_W - 1 - DV_PER * d - j;
          if (bp >= 0) begin
            r_c[i] = {r_c[i][ROOT_W-1:0], dn[d][i][bp]};
            if (r_c[i] >= (ROOT_W+1)'(dl[d])) begin
              r_c[i]     = r_c[i] - (ROOT_W+1)'(dl[d]);
              q_c[i][bp] = 1'b1;
            end
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dl[d+1] <= dl[d];
        dz[d+1] <= dz[d];
        for (int i = 0; i < 3; i++) begin
          dr[d+1][i]   <= r_c[i];
          dq[d+1][i]   <= q_c[i];
          dn[d+1][i]   <= dn[d][i];
          dneg[d+1][i] <= dneg[d][i];
        end
      end
    end
  end

  // Output stage: saturate to one, restore the sign, zero vector to zero.
  logic [Q_W-1:0] qs_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qs_c[i] = (dq[DV_ST][i] > Q_W'(VEC_ONE)) ? Q_W'(VEC_ONE) : dq[DV_ST][i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dz[DV_ST]) begin
          res[i] <= '0;
        end else if (dneg[DV_ST][i]) begin
          res[i] <= -$signed(VEC_WIDTH'(qs_c[i]));
        end else begin
          res[i] <= $signed(VEC_WIDTH'(qs_c[i]));
        end
      end
    end
  end

endmodule

>>> rtl/triangle_tangent_calc_core.sv
// ----------------------------------------------------------------------------
// triangle_tangent_calc_core: per-triangle tangent and handedness
// Takes one triangle per item and returns its unit tangent, handedness
// and a flag for a degenerate texture mapping.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries three positions, three texture coordinates
//   and the face normal; an item is taken when in_valid is high and
//   in_stall is low. The output channel carries tangent_x/y/z, left_handed
//   and degenerate_uv; an item leaves when out_valid is high and out_stall
//   is low.
//   The pipeline holds two passes through the normalizer pipeline, whose
//   square root and divide stages set its depth, plus seven stages of edge,
//   product and dot logic.
//   Throughput is one item per cycle. The whole pipeline moves together:
//   when the output holds an item and out_stall is high, every stage holds
//   and in_stall is raised; otherwise bubbles move forward and a new item
//   can enter each cycle. Reset clears the valid bits of all stages, so the
//   pipeline comes out empty.
// ----------------------------------------------------------------------------
module triangle_tangent_calc_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [3*tcc_pkg::POS_WIDTH-1:0]   pos_a,
  input  logic [3*tcc_pkg::POS_WIDTH-1:0]   pos_b,
  input  logic [3*tcc_pkg::POS_WIDTH-1:0]   pos_c,
  input  logic [2*tcc_pkg::UV_WIDTH-1:0]    uv_a,
  input  logic [2*tcc_pkg::UV_WIDTH-1:0]    uv_b,
  input  logic [2*tcc_pkg::UV_WIDTH-1:0]    uv_c,
  input  logic [3*tcc_pkg::VEC_WIDTH-1:0]   face_normal,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [tcc_pkg::VEC_WIDTH-1:0] tangent_x,
  output logic signed [tcc_pkg::VEC_WIDTH-1:0] tangent_y,
  output logic signed [tcc_pkg::VEC_WIDTH-1:0] tangent_z,
  output logic                              left_handed,
  output logic                              degenerate_uv
);
  import tcc_pkg::*;

  localparam int NL    = NRM_LAT;
  localparam int LAT   = 2 * NL + 7;
  localparam int DET_W = 2 * VEC_WIDTH + 1;
  localparam int CR_W  = 2 * VEC_WIDTH + 1;
  localparam int DP_W  = CR_W + VEC_WIDTH;
  localparam int DOT_W = DP_W + 2;

  logic           en;
  logic [LAT-1:0] vld;

  assign en        = !vld[LAT-1] || !out_stall;
  assign in_stall  = !en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // Stage 0: edges and texture edges.
  nin_t ev1_c [3], ev2_c [3], uv1_c [3], uv2_c [3];
  vec_t nrm_c [3];
  nin_t ev1 [3], ev2 [3], uv1 [3], uv2 [3];
  vec_t nd [2*NL+3][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ev1_c[i] = NIN_W'($signed(pos_b[i*POS_WIDTH +: POS_WIDTH]))
               - NIN_W'($signed(pos_a[i*POS_WIDTH +: POS_WIDTH]));
      ev2_c[i] = NIN_W'($signed(pos_c[i*POS_WIDTH +: POS_WIDTH]))
               - NIN_W'($signed(pos_a[i*POS_WIDTH +: POS_WIDTH]));
      nrm_c[i] = face_normal[i*VEC_WIDTH +: VEC_WIDTH];
    end
    for (int i = 0; i < 2; i++) begin
      uv1_c[i] = NIN_W'($signed(uv_b[i*UV_WIDTH +: UV_WIDTH]))
               - NIN_W'($signed(uv_a[i*UV_WIDTH +: UV_WIDTH]));
      uv2_c[i] = NIN_W'($signed(uv_c[i*UV_WIDTH +: UV_WIDTH]))
               - NIN_W'($signed(uv_a[i*UV_WIDTH +: UV_WIDTH]));
    end
    uv1_c[2] = '0;
    uv2_c[2] = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ev1   <= ev1_c;
      ev2   <= ev2_c;
      uv1   <= uv1_c;
      uv2   <= uv2_c;
      nd[0] <= nrm_c;
      for (int k = 1; k < 2 * NL + 3; k++) begin
        nd[k] <= nd[k-1];
      end
    end
  end

  // First normalizer pass.
  vec_t n1 [3], n2 [3], te1 [3], te2 [3];

  tcc_norm u_norm_e1 (.clk(clk), .en(en), .vec(ev1), .res(n1));
  tcc_norm u_norm_e2 (.clk(clk), .en(en), .vec(ev2), .res(n2));
  tcc_norm u_norm_d1 (.clk(clk), .en(en), .vec(uv1), .res(te1));
  tcc_norm u_norm_d2 (.clk(clk), .en(en), .vec(uv2), .res(te2));

  // Stage T1: determinant and basis products.
  prod_t pdet0, pdet1;
  prod_t pt1 [3], pt2 [3], pb1 [3], pb2 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      pdet0 <= te1[0] * te2[1];
      pdet1 <= te1[1] * te2[0];
      for (int i = 0; i < 3; i++) begin
        pt1[i] <= te2[1] * n1[i];
        pt2[i] <= te1[1] * n2[i];
        pb1[i] <= te1[0] * n2[i];
        pb2[i] <= te2[0] * n1[i];
      end
    end
  end

  // Stage T2: determinant sign applied to the unnormalized basis.
  logic signed [DET_W-1:0] det_c;
  nin_t rt_c [3], rb_c [3];
  nin_t rt2 [3], rb2 [3];
  logic dgd [NL+1];

  always_comb begin
    det_c = DET_W'(pdet0) - DET_W'(pdet1);
    for (int i = 0; i < 3; i++) begin
      rt_c[i] = NIN_W'(pt1[i]) - NIN_W'(pt2[i]);
      rb_c[i] = NIN_W'(pb1[i]) - NIN_W'(pb2[i]);
      if (det_c < 0) begin
        rt_c[i] = -rt_c[i];
        rb_c[i] = -rb_c[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rt2    <= rt_c;
      rb2    <= rb_c;
      dgd[0] <= (det_c == '0);
      for (int k = 1; k < NL + 1; k++) begin
        dgd[k] <= dgd[k-1];
      end
    end
  end

  // Second normalizer pass.
  vec_t tv [3], bv [3];

  tcc_norm u_norm_t (.clk(clk), .en(en), .vec(rt2), .res(tv));
  tcc_norm u_norm_b (.clk(clk), .en(en), .vec(rb2), .res(bv));

  // Stage T3: fallback basis and cross product terms.
  vec_t  tt_c [3], bb_c [3];
  vec_t  t3 [3], b3 [3];
  prod_t c3a [3], c3b [3];
  logic  dg3;

  always_comb begin
    if (dgd[NL]) begin
      tt_c[0] = VEC_ONE;
      tt_c[1] = '0;
      tt_c[2] = '0;
      bb_c[0] = '0;
      bb_c[1] = VEC_ONE;
      bb_c[2] = '0;
    end else begin
      tt_c = tv;
      bb_c = bv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t3     <= tt_c;
      b3     <= bb_c;
      dg3    <= dgd[NL];
      c3a[0] <= nd[2*NL+2][1] * tt_c[2];
      c3b[0] <= nd[2*NL+2][2] * tt_c[1];
      c3a[1] <= nd[2*NL+2][2] * tt_c[0];
      c3b[1] <= nd[2*NL+2][0] * tt_c[2];
      c3a[2] <= nd[2*NL+2][0] * tt_c[1];
      c3b[2] <= nd[2*NL+2][1] * tt_c[0];
    end
  end

  // Stage T4: cross product.
  logic signed [CR_W-1:0] cr4 [3];
  vec_t t4 [3], b4 [3];
  logic dg4;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        cr4[i] <= CR_W'(c3a[i]) - CR_W'(c3b[i]);
      end
      t4  <= t3;
      b4  <= b3;
      dg4 <= dg3;
    end
  end

  // Stage T5: dot product terms.
  logic signed [DP_W-1:0] dp5 [3];
  vec_t t5 [3];
  logic dg5;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dp5[i] <= cr4[i] * b4[i];
      end
      t5  <= t4;
      dg5 <= dg4;
    end
  end

  // Stage T6: handedness and output register.
  logic signed [DOT_W-1:0] dot_c;

  assign dot_c = DOT_W'(dp5[0]) + DOT_W'(dp5[1]) + DOT_W'(dp5[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      tangent_x     <= t5[0];
      tangent_y     <= t5[1];
      tangent_z     <= t5[2];
      left_handed   <= (dot_c < 0);
      degenerate_uv <= dg5;
    end
  end

endmodule
